>>> hw/rtl/per_flow_token_bucket_policer_unit_macros.svh
// Assertion macros for the per-flow token bucket policer.
// Used by the top level; expects clk and rst in scope.
`ifndef PER_FLOW_TOKEN_BUCKET_POLICER_UNIT_MACROS_SVH
`define PER_FLOW_TOKEN_BUCKET_POLICER_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define PFTBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PFTBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pftbp_pkg.sv
// Shared types and constants for the per-flow token bucket policer.
// No dependencies; imported by the interfaces and all modules.
package pftbp_pkg;

  localparam int IDX_IN_W   = 10;
  localparam int LEN_W      = 16;
  localparam int TIME_W     = 48;
  localparam int TOK_W      = 48;
  localparam int ACT_W      = 2;
  localparam int RATE_W     = 24;
  localparam int CAP_W      = 40;
  localparam int SPLIT_W    = 20;
  localparam int PROD_HALF_W = SPLIT_W + RATE_W;
  localparam int PROD_W     = 64;

  localparam int REFILL_STAGES = 5;

  localparam logic FUNC_POLICE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  localparam logic [ACT_W-1:0] ACT_PASS  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LIMIT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROP  = 2'd2;

  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  localparam logic [TOK_W-1:0] TOK_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [TOK_W-1:0] TOK_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [CAP_W-1:0]  cap;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] last;
  } entry_t;

  typedef struct packed {
    logic act_we;
    logic par_we;
  } tbl_wr_t;

  typedef struct packed {
    logic              done;
    logic              drop;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] last;
  } refill_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INDEX,
    S_LOAD,
    S_READ,
    S_ACT,
    S_WAIT,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/pftbp_if.sv
// Valid/ready channel interfaces for the policer request and response words.
// Depends on pftbp_pkg for field widths.
interface pftbp_in_if import pftbp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [IDX_IN_W-1:0]        contract_index;
  logic [LEN_W-1:0]           packet_length;
  logic [TIME_W-1:0]          now_ms;
  logic signed [TOK_W-1:0]    kern_tokens;
  logic [ACT_W-1:0]           new_action;
  logic [RATE_W-1:0]          new_rate;
  logic [CAP_W-1:0]           new_capacity;

  modport source(output valid, func, contract_index, packet_length, now_ms, kern_tokens,
                 new_action, new_rate, new_capacity, input ready);
  modport sink(input valid, func, contract_index, packet_length, now_ms, kern_tokens,
               new_action, new_rate, new_capacity, output ready);
endinterface

interface pftbp_out_if import pftbp_pkg::*; ();
  logic valid;
  logic ready;
  logic verdict;

  modport source(output valid, verdict, input ready);
  modport sink(input valid, verdict, output ready);
endinterface

>>> hw/rtl/per_flow_token_bucket_policer_unit.sv
// Per-flow token bucket policer: one word at a time, sequencer around the tables.
// Load word: index reduction, then table write. Pass/drop packet: index reduction,
// registered table read, action check, then the result register. Limit packet: the same,
// with the five-stage refill datapath between the action check and the result register.
// Reset: the action table is cleared to pass, and no word is accepted until it is done.
// The result register lets a packet be accepted while the previous verdict waits.
`include "per_flow_token_bucket_policer_unit_macros.svh"

module per_flow_token_bucket_policer_unit import pftbp_pkg::*; #(
  parameter int CONTRACTS = 1024
) (
  input logic         clk,
  input logic         rst,
  pftbp_in_if.sink    req,
  pftbp_out_if.source rsp
);

  localparam int IW      = $clog2(CONTRACTS);
  localparam int CW      = $clog2(CONTRACTS + 1);
  localparam int PW      = IDX_IN_W + CW;
  localparam int RECIP_W = IDX_IN_W + 1;
  localparam int QW      = IDX_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << IDX_IN_W) / CONTRACTS);
  localparam logic [PW-1:0] CONTRACTS_PW = PW'(CONTRACTS);

  state_t state, state_next;

  logic                func_r;
  logic [IDX_IN_W-1:0] cidx_r;
  logic [LEN_W-1:0]    len_r;
  logic [TIME_W-1:0]   now_r;
  logic [TOK_W-1:0]    kern_r;
  logic [ACT_W-1:0]    act_in_r;
  logic [RATE_W-1:0]   rate_in_r;
  logic [CAP_W-1:0]    cap_in_r;
  logic [IDX_IN_W-1:0] quo_r;
  logic [IW-1:0]       idx;
  logic                drop_r;
  logic                wr_par;
  entry_t              upd;
  logic                rsp_valid;
  logic                rsp_verdict;

  logic [QW-1:0] qprod;
  logic [PW-1:0] qc;
  logic [PW-1:0] rem;
  logic [PW-1:0] rem_fix;

  tbl_wr_t          tbl_wr;
  logic [ACT_W-1:0] act_q;
  entry_t           par_q;
  entry_t           wr_entry;
  logic             tbl_busy;
  logic             rf_start;
  refill_rsp_t      rf_rsp;
  logic             out_free;
  logic             done_fire;
  logic             accept;

  pftbp_tables #(.CONTRACTS(CONTRACTS)) u_tables (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx),
    .wr_addr  (idx),
    .wr       (tbl_wr),
    .wr_act   (act_in_r),
    .wr_entry (wr_entry),
    .act_q    (act_q),
    .par_q    (par_q),
    .busy     (tbl_busy)
  );

  pftbp_refill u_refill (
    .clk           (clk),
    .rst           (rst),
    .start         (rf_start),
    .entry         (par_q),
    .now_ms        (now_r),
    .kern_tokens   (kern_r),
    .packet_length (len_r),
    .rsp           (rf_rsp)
  );

  // Index modulo CONTRACTS: reciprocal estimate at accept, one correction later.
  assign qprod   = QW'(req.contract_index) * QW'(RECIP);
  assign qc      = PW'(quo_r) * CONTRACTS_PW;
  assign rem     = PW'(cidx_r) - qc;
  assign rem_fix = (rem >= CONTRACTS_PW) ? rem - CONTRACTS_PW : rem;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rf_start   = 1'b0;
    tbl_wr     = '0;
    done_fire  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = !tbl_busy;
        if (req.valid && !tbl_busy) state_next = S_INDEX;
      end
      S_INDEX: begin
        state_next = (func_r == FUNC_LOAD) ? S_LOAD : S_READ;
      end
      S_LOAD: begin
        tbl_wr.act_we = 1'b1;
        tbl_wr.par_we = 1'b1;
        state_next    = S_IDLE;
      end
      S_READ: begin
        state_next = S_ACT;
      end
      S_ACT: begin
        if (act_q == ACT_LIMIT) begin
          rf_start   = 1'b1;
          state_next = S_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WAIT: begin
        if (rf_rsp.done) state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (out_free) begin
          done_fire     = 1'b1;
          tbl_wr.par_we = wr_par;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state == S_LOAD) begin
      wr_entry.rate   = rate_in_r;
      wr_entry.cap    = cap_in_r;
      wr_entry.tokens = '0;
      wr_entry.last   = '0;
    end else begin
      wr_entry = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= req.func;
      cidx_r    <= req.contract_index;
      len_r     <= req.packet_length;
      now_r     <= req.now_ms;
      kern_r    <= req.kern_tokens;
      act_in_r  <= req.new_action;
      rate_in_r <= req.new_rate;
      cap_in_r  <= req.new_capacity;
      quo_r     <= qprod[IDX_IN_W +: IDX_IN_W];
    end
    if (state == S_INDEX) idx <= rem_fix[IW-1:0];
    if (state == S_ACT) drop_r <= (act_q == ACT_DROP);
    if (state == S_WAIT && rf_rsp.done) begin
      drop_r     <= rf_rsp.drop;
      upd.rate   <= par_q.rate;
      upd.cap    <= par_q.cap;
      upd.tokens <= rf_rsp.tokens;
      upd.last   <= rf_rsp.last;
    end
    if (done_fire) rsp_verdict <= drop_r ? VERDICT_DROP : VERDICT_PASS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_par    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_ACT) wr_par <= 1'b0;
      else if (state == S_WAIT && rf_rsp.done) wr_par <= 1'b1;
      if (done_fire) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.verdict = rsp_verdict;

  `PFTBP_ASSERT_NOW(a_no_accept_clearing, tbl_busy, !req.ready, "word accepted during clear")
  `PFTBP_ASSERT_NEXT(a_one_in_flight, accept, !req.ready, "second word accepted in flight")
  `PFTBP_ASSERT_NOW(a_refill_latency, rf_rsp.done, $past(rf_start, REFILL_STAGES), "refill done without start")
  `PFTBP_ASSERT_NOW(a_result_is_police, done_fire, func_r == FUNC_POLICE, "result from load word")

endmodule

>>> hw/rtl/pftbp_tables.sv
// Contract storage: action memory with a clearing pass after reset, and an
// entry memory for rate, capacity, tokens and last refill time. Uses pftbp_pkg.
module pftbp_tables import pftbp_pkg::*; #(
  parameter int CONTRACTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(CONTRACTS)-1:0] rd_addr,
  input  logic [$clog2(CONTRACTS)-1:0] wr_addr,
  input  tbl_wr_t                      wr,
  input  logic [ACT_W-1:0]             wr_act,
  input  entry_t                       wr_entry,
  output logic [ACT_W-1:0]             act_q,
  output entry_t                       par_q,
  output logic                         busy
);

  localparam int IW = $clog2(CONTRACTS);

  logic [ACT_W-1:0] act_mem [CONTRACTS];
  entry_t           par_mem [CONTRACTS];

  logic          clr_active;
  logic [IW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == IW'(CONTRACTS - 1)) clr_active <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      act_mem[clr_addr] <= ACT_PASS;
    end else if (wr.act_we) begin
      act_mem[wr_addr] <= wr_act;
    end
    act_q <= act_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.par_we) par_mem[wr_addr] <= wr_entry;
    par_q <= par_mem[rd_addr];
  end

  assign busy = clr_active;

endmodule

>>> hw/rtl/pftbp_refill.sv
// Five-stage refill and admission datapath for one limit contract.
// Inputs hold steady from start until done. Uses pftbp_pkg.
module pftbp_refill import pftbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  entry_t            entry,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [TOK_W-1:0]  kern_tokens,
  input  logic [LEN_W-1:0]  packet_length,
  output refill_rsp_t       rsp
);

  logic [REFILL_STAGES-1:0] vld;

  logic [TIME_W-1:0]      elapsed;
  logic                   later1;
  logic                   big1;
  logic                   tokpos1;
  logic [TOK_W:0]         room1;
  logic [SPLIT_W-1:0]     elhi1;
  logic [PROD_HALF_W-1:0] plo1;
  logic [PROD_HALF_W-1:0] phi2;
  logic [PROD_W-1:0]      prod3;
  logic [TOK_W-1:0]       tokref4;
  logic [TOK_W-1:0]       tokref_next;
  logic                   over;
  logic [TOK_W-1:0]       cap_ext;
  logic [TOK_W:0]         sum;
  logic [TOK_W:0]         debit;
  logic [TOK_W-1:0]       debit_sat;
  logic                   admit;
  logic                   drop5;
  logic [TOK_W-1:0]       tok5;
  logic [TIME_W-1:0]      last5;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[REFILL_STAGES-2:0], start};
  end

  assign elapsed = now_ms - entry.last;
  assign cap_ext = {{(TOK_W - CAP_W){1'b0}}, entry.cap};

  // Stage 1: elapsed time, room left, low partial product.
  always_ff @(posedge clk) begin
    later1  <= now_ms > entry.last;
    big1    <= (|elapsed[TIME_W-1:CAP_W]) && (entry.rate != '0);
    tokpos1 <= $signed(entry.tokens) > $signed(TOK_W'(0));
    room1   <= $signed({1'b0, cap_ext}) - $signed({entry.tokens[TOK_W-1], entry.tokens});
    elhi1   <= elapsed[CAP_W-1:SPLIT_W];
    plo1    <= PROD_HALF_W'(elapsed[SPLIT_W-1:0]) * PROD_HALF_W'(entry.rate);
  end

  // Stage 2: high partial product.
  always_ff @(posedge clk) begin
    phi2 <= PROD_HALF_W'(elhi1) * PROD_HALF_W'(entry.rate);
  end

  // Stage 3: combine partial products.
  always_ff @(posedge clk) begin
    prod3 <= {phi2, {SPLIT_W{1'b0}}} + {{(PROD_W - PROD_HALF_W){1'b0}}, plo1};
  end

  // Stage 4: refilled token count, clamped to capacity.
  always_comb begin
    over = big1 || (prod3 > {{(PROD_W - TOK_W){1'b0}}, room1[TOK_W-1:0]});
    if (!later1) begin
      tokref_next = entry.tokens;
    end else if (!tokpos1) begin
      tokref_next = entry.tokens + cap_ext;
    end else if ($signed(room1) <= $signed((TOK_W+1)'(0)) || over) begin
      tokref_next = cap_ext;
    end else begin
      tokref_next = entry.tokens + prod3[TOK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    tokref4 <= tokref_next;
  end

  // Stage 5: admit against twice the bit count, debit once, saturate.
  always_comb begin
    sum   = $signed({kern_tokens[TOK_W-1], kern_tokens}) +
            $signed({tokref4[TOK_W-1], tokref4});
    admit = $signed(sum) >=
            $signed({{(TOK_W + 1 - LEN_W - 4){1'b0}}, packet_length, 4'b0000});
    debit = $signed({tokref4[TOK_W-1], tokref4}) -
            $signed({{(TOK_W + 1 - LEN_W - 3){1'b0}}, packet_length, 3'b000});
    if (debit[TOK_W] != debit[TOK_W-1]) begin
      debit_sat = debit[TOK_W] ? TOK_MIN : TOK_MAX;
    end else begin
      debit_sat = debit[TOK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    drop5 <= !admit;
    tok5  <= admit ? debit_sat : tokref4;
    last5 <= later1 ? now_ms : entry.last;
  end

  assign rsp.done   = vld[REFILL_STAGES-1];
  assign rsp.drop   = drop5;
  assign rsp.tokens = tok5;
  assign rsp.last   = last5;

endmodule
